### src/bor_pkg.sv
// Shared types, register indexes and the screen position mapping of the bitmap outline renderer.
// Depends on nothing. Used by src/bitmap_outline_renderer.sv and the testbench in tb/sv.
package bor_pkg;

   localparam int unsigned DIM_WIDTH   = 10;
   localparam int unsigned COORD_WIDTH = 16;
   localparam int unsigned COLOR_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_X     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_Y     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FILL_COLOR   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EDGE_COLOR   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIENTATION  = 3'd6;

   // Orientation codes. Anything not listed behaves as no transform.
   localparam logic [2:0] ORIENT_NONE         = 3'd0;
   localparam logic [2:0] ORIENT_HFLIP        = 3'd1;
   localparam logic [2:0] ORIENT_VFLIP        = 3'd2;
   localparam logic [2:0] ORIENT_BOTH         = 3'd3;
   localparam logic [2:0] ORIENT_ROTLEFT      = 3'd4;
   localparam logic [2:0] ORIENT_HFLIP_ROT    = 3'd5;
   localparam logic [2:0] ORIENT_VFLIP_ROT    = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PEND  = 4'b0010,
      ST_BITS  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   // One pixel write before it is mapped to the screen.
   typedef struct packed {
      logic [DIM_WIDTH-1:0]   column;
      logic [DIM_WIDTH-1:0]   row;
      logic [COLOR_WIDTH-1:0] color;
   } pixel_type;

   // Screen position of bitmap pixel (col, row): returns {x, y}, all 16-bit wrapping.
   function automatic logic [2*COORD_WIDTH-1:0] map_position(
      input logic [DIM_WIDTH-1:0]   col,
      input logic [DIM_WIDTH-1:0]   row,
      input logic [DIM_WIDTH-1:0]   width,
      input logic [DIM_WIDTH-1:0]   height,
      input logic [2:0]             orient,
      input logic [COORD_WIDTH-1:0] ox,
      input logic [COORD_WIDTH-1:0] oy
   );
      logic [COORD_WIDTH-1:0] c16;
      logic [COORD_WIDTH-1:0] r16;
      logic [COORD_WIDTH-1:0] cflip;
      logic [COORD_WIDTH-1:0] rflip;
      logic [COORD_WIDTH-1:0] fx;
      logic [COORD_WIDTH-1:0] fy;
      c16   = {6'd0, col};
      r16   = {6'd0, row};
      cflip = {6'd0, width} - 16'd1 - c16;
      rflip = {6'd0, height} - 16'd1 - r16;
      case (orient)
         ORIENT_HFLIP: begin
            fx = cflip; fy = r16;
         end
         ORIENT_VFLIP: begin
            fx = c16; fy = rflip;
         end
         ORIENT_BOTH: begin
            fx = cflip; fy = rflip;
         end
         ORIENT_ROTLEFT: begin
            fx = r16; fy = cflip;
         end
         ORIENT_HFLIP_ROT: begin
            fx = r16; fy = c16;
         end
         ORIENT_VFLIP_ROT: begin
            fx = rflip; fy = cflip;
         end
         default: begin
            fx = c16; fy = r16;
         end
      endcase
      return {ox + fx, oy + fy};
   endfunction

endpackage

### src/bitmap_outline_renderer.sv
// Top level of the bitmap outline renderer: bit-serial walk over each bitmap byte.
// Depends on src/bor_pkg.sv for types, register indexes and position mapping.
//
// Usage: the request channel (req_valid, req_stall, req_bitmap_byte) takes the packed
// one-bit bitmap one byte per transaction, rows padded to whole bytes, MSB first. Every
// set pixel inside the row becomes one transaction on the response channel (rsp_valid,
// rsp_stall, rsp_*) carrying screen x/y and color; rsp_last_of_run marks the last write
// caused by a byte. A byte may cause no response at all.
// The csr channel writes the seven configuration registers; csr_ready is always high.
// Write them only while no byte is in flight.
// Timing: a byte is shifted out one bit per cycle while the response channel does not
// stall; a pixel left pending by the previous byte is resolved first. The next byte is
// accepted only once the walk is back in idle after the flush state. One write is held
// back so that the last one can be marked; the last one is loaded in the flush cycle.
// A stall on the response channel freezes the bit walk; the request side then stalls.
// Reset (synchronous, active high) restores width and height 8, everything else zero,
// and returns the walk to column 0 of row 0 with no pending pixel.
module bitmap_outline_renderer
   import bor_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_bitmap_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_screen_x,
   output logic signed [COORD_WIDTH-1:0] rsp_screen_y,
   output logic [COLOR_WIDTH-1:0]     rsp_pixel_color,
   output logic                       rsp_last_of_run,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Configuration registers.
   logic [DIM_WIDTH-1:0]   width_ff;
   logic [DIM_WIDTH-1:0]   height_ff;
   logic [COORD_WIDTH-1:0] origin_x_ff;
   logic [COORD_WIDTH-1:0] origin_y_ff;
   logic [COLOR_WIDTH-1:0] fill_color_ff;
   logic [COLOR_WIDTH-1:0] edge_color_ff;
   logic [2:0]             orient_ff;

   // Walk state that persists from byte to byte.
   state_type              state_ff,     state_in;
   logic [DIM_WIDTH-1:0]   col_ff,       col_in;
   logic [DIM_WIDTH-1:0]   row_ff,       row_in;
   logic                   left_ff,      left_in;
   logic                   pend_ff,      pend_in;
   logic [DIM_WIDTH-1:0]   pend_col_ff,  pend_col_in;
   logic [DIM_WIDTH-1:0]   pend_row_ff,  pend_row_in;

   // Per-byte serial datapath: the byte shifts left, bit 7 is the current pixel.
   logic [7:0]             shift_ff,     shift_in;
   logic [2:0]             bit_cnt_ff,   bit_cnt_in;
   logic [DIM_WIDTH:0]     cur_col_ff,   cur_col_in;

   // One write is held so the final write of a byte can be flagged.
   logic                   hold_valid_ff, hold_valid_in;
   pixel_type              hold_ff,       hold_in;

   // Response output register.
   logic                   out_valid_ff,  out_valid_in;
   logic [COORD_WIDTH-1:0] out_x_ff,      out_x_in;
   logic [COORD_WIDTH-1:0] out_y_ff,      out_y_in;
   logic [COLOR_WIDTH-1:0] out_color_ff,  out_color_in;
   logic                   out_last_ff,   out_last_in;

   logic                   out_free;
   logic                   new_valid;
   pixel_type              new_pix;
   logic                   load_out;
   logic                   load_last;
   logic                   in_range;
   logic                   at_row_end;
   logic [DIM_WIDTH:0]     next_col_sum;
   logic [DIM_WIDTH:0]     next_row_sum;
   logic [2*COORD_WIDTH-1:0] mapped;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid       = out_valid_ff;
   assign rsp_screen_x    = out_x_ff;
   assign rsp_screen_y    = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last_of_run = out_last_ff;

   // The walk advances only when the output register can take a write this cycle.
   assign out_free = !out_valid_ff || !rsp_stall;

   assign in_range     = cur_col_ff < {1'b0, width_ff};
   assign at_row_end   = cur_col_ff == ({1'b0, width_ff} - 11'd1);
   assign next_col_sum = {1'b0, col_ff} + 11'd8;
   assign next_row_sum = {1'b0, row_ff} + 11'd1;

   assign mapped = map_position(hold_ff.column, hold_ff.row, width_ff, height_ff,
                                orient_ff, origin_x_ff, origin_y_ff);

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      pend_col_in   = pend_col_ff;
      pend_row_in   = pend_row_ff;
      shift_in      = shift_ff;
      bit_cnt_in    = bit_cnt_ff;
      cur_col_in    = cur_col_ff;
      new_valid     = 1'b0;
      new_pix       = '{column: cur_col_ff[DIM_WIDTH-1:0], row: row_ff, color: edge_color_ff};
      load_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               shift_in   = req_bitmap_byte;
               bit_cnt_in = 3'd0;
               cur_col_in = {1'b0, col_ff};
               state_in   = pend_ff ? ST_PEND : ST_BITS;
            end
         end
         ST_PEND: begin
            if (out_free) begin
               // The held pixel is resolved by the first bit of this byte.
               new_valid = 1'b1;
               new_pix   = '{column: pend_col_ff, row: pend_row_ff,
                             color: shift_ff[7] ? fill_color_ff : edge_color_ff};
               pend_in   = 1'b0;
               state_in  = ST_BITS;
            end
         end
         ST_BITS: begin
            if (out_free) begin
               if (in_range) begin
                  if (shift_ff[7]) begin
                     if (!left_ff || at_row_end) begin
                        new_valid = 1'b1;
                     end else if (bit_cnt_ff != 3'd7) begin
                        new_valid     = 1'b1;
                        new_pix.color = shift_ff[6] ? fill_color_ff : edge_color_ff;
                     end else begin
                        // Right neighbor lives in the next byte.
                        pend_in     = 1'b1;
                        pend_col_in = cur_col_ff[DIM_WIDTH-1:0];
                        pend_row_in = row_ff;
                     end
                  end
                  left_in = shift_ff[7];
               end
               shift_in   = {shift_ff[6:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + 3'd1;
               cur_col_in = cur_col_ff + 11'd1;
               if (bit_cnt_ff == 3'd7) begin
                  if (next_col_sum >= {1'b0, width_ff}) begin
                     col_in  = '0;
                     left_in = 1'b0;
                     if (next_row_sum >= {1'b0, height_ff}) begin
                        row_in = '0;
                     end else begin
                        row_in = next_row_sum[DIM_WIDTH-1:0];
                     end
                  end else begin
                     col_in = next_col_sum[DIM_WIDTH-1:0];
                  end
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               load_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A new write pushes the held one out; the flush cycle releases it as the last.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      load_out      = 1'b0;
      if (new_valid) begin
         load_out      = hold_valid_ff;
         hold_valid_in = 1'b1;
         hold_in       = new_pix;
      end else if (load_last) begin
         load_out      = hold_valid_ff;
         hold_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = load_out;
         if (load_out) begin
            out_x_in     = mapped[2*COORD_WIDTH-1:COORD_WIDTH];
            out_y_in     = mapped[COORD_WIDTH-1:0];
            out_color_in = hold_ff.color;
            out_last_in  = load_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 10'd8;
         height_ff     <= 10'd8;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         fill_color_ff <= '0;
         edge_color_ff <= '0;
         orient_ff     <= ORIENT_NONE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff      <= csr_wdata[DIM_WIDTH-1:0];
            REG_IMAGE_HEIGHT: height_ff     <= csr_wdata[DIM_WIDTH-1:0];
            REG_ORIGIN_X:     origin_x_ff   <= csr_wdata;
            REG_ORIGIN_Y:     origin_y_ff   <= csr_wdata;
            REG_FILL_COLOR:   fill_color_ff <= csr_wdata;
            REG_EDGE_COLOR:   edge_color_ff <= csr_wdata;
            REG_ORIENTATION:  orient_ff     <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         pend_col_ff   <= '0;
         pend_row_ff   <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_ff       <= left_in;
         pend_ff       <= pend_in;
         pend_col_ff   <= pend_col_in;
         pend_row_ff   <= pend_row_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      bit_cnt_ff   <= bit_cnt_in;
      cur_col_ff   <= cur_col_in;
      hold_ff      <= hold_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

endmodule

### tb/sv/bitmap_outline_renderer_checker.sv
// Checker for the bitmap outline renderer: watches the csr, request and response channels.
// Predicts the pixel writes of every accepted bitmap byte and compares the responses in order.
// Depends on src/bor_pkg.sv for register indexes, orientation codes and widths.
module bitmap_outline_renderer_checker
   import bor_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [7:0]                    req_bitmap_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [COORD_WIDTH-1:0] rsp_screen_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_screen_y,
   input  logic [COLOR_WIDTH-1:0]        rsp_pixel_color,
   input  logic                          rsp_last_of_run,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            writes_due,
   output int                            writes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [COLOR_WIDTH-1:0] color;
      logic                   last;
   } pixel_write_type;

   pixel_write_type expected_writes[$];

   // Register copies.
   logic [DIM_WIDTH-1:0]   img_width;
   logic [DIM_WIDTH-1:0]   img_height;
   logic [COORD_WIDTH-1:0] org_x;
   logic [COORD_WIDTH-1:0] org_y;
   logic [COLOR_WIDTH-1:0] fill_rgb;
   logic [COLOR_WIDTH-1:0] outline_rgb;
   logic [2:0]             orient_code;

   // Walk state.
   int   next_col;
   int   cur_row;
   logic left_on;
   logic held_valid;
   int   held_col;
   int   held_row;

   function automatic pixel_write_type place_pixel(input int col, input int row,
                                                   input logic [COLOR_WIDTH-1:0] color);
      pixel_write_type pw;
      logic [15:0] cc;
      logic [15:0] rr;
      logic [15:0] c_mirror;
      logic [15:0] r_mirror;
      logic [15:0] dx;
      logic [15:0] dy;
      cc       = col[15:0];
      rr       = row[15:0];
      c_mirror = {6'd0, img_width} - 16'd1 - cc;
      r_mirror = {6'd0, img_height} - 16'd1 - rr;
      dx = cc;
      dy = rr;
      case (orient_code)
         ORIENT_HFLIP:     dx = c_mirror;
         ORIENT_VFLIP:     dy = r_mirror;
         ORIENT_BOTH: begin
            dx = c_mirror;
            dy = r_mirror;
         end
         ORIENT_ROTLEFT: begin
            dx = rr;
            dy = c_mirror;
         end
         ORIENT_HFLIP_ROT: begin
            dx = rr;
            dy = cc;
         end
         ORIENT_VFLIP_ROT: begin
            dx = r_mirror;
            dy = c_mirror;
         end
         default: ;
      endcase
      pw.x     = org_x + dx;
      pw.y     = org_y + dy;
      pw.color = color;
      pw.last  = 1'b0;
      return pw;
   endfunction

   // Walks one byte through the current row and queues the pixel writes it causes.
   function automatic void render_byte(input logic [7:0] bits);
      pixel_write_type run [0:8];
      int   n;
      int   c;
      int   w;
      int   h;
      logic on;
      n = 0;
      w = img_width;
      h = img_height;
      // A pixel held from the previous byte is decided by this byte's first bit.
      if (held_valid) begin
         run[n] = place_pixel(held_col, held_row, bits[7] ? fill_rgb : outline_rgb);
         n++;
         held_valid = 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
         c  = next_col + i;
         on = bits[7-i];
         if (c < w) begin
            if (on) begin
               if (!left_on || c == w - 1) begin
                  run[n] = place_pixel(c, cur_row, outline_rgb);
                  n++;
               end else if (i < 7) begin
                  run[n] = place_pixel(c, cur_row, bits[6-i] ? fill_rgb : outline_rgb);
                  n++;
               end else begin
                  held_valid = 1'b1;
                  held_col   = c & 'h3FF;
                  held_row   = cur_row & 'h3FF;
               end
            end
            left_on = on;
         end
      end
      next_col += 8;
      if (next_col >= w) begin
         next_col = 0;
         left_on  = 1'b0;
         cur_row++;
         if (cur_row >= h)
            cur_row = 0;
      end
      next_col &= 'h3FF;
      cur_row  &= 'h3FF;
      if (n > 0)
         run[n-1].last = 1'b1;
      for (int k = 0; k < n; k++)
         expected_writes.push_back(run[k]);
   endfunction

   always @(posedge clock) begin : watch
      pixel_write_type due;
      if (reset) begin
         img_width      = 10'd8;
         img_height     = 10'd8;
         org_x          = '0;
         org_y          = '0;
         fill_rgb       = '0;
         outline_rgb    = '0;
         orient_code    = ORIENT_NONE;
         next_col       = 0;
         cur_row        = 0;
         left_on        = 1'b0;
         held_valid     = 1'b0;
         held_col       = 0;
         held_row       = 0;
         mismatch_count = 0;
         writes_checked = 0;
         expected_writes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  img_width   = csr_wdata[DIM_WIDTH-1:0];
               REG_IMAGE_HEIGHT: img_height  = csr_wdata[DIM_WIDTH-1:0];
               REG_ORIGIN_X:     org_x       = csr_wdata;
               REG_ORIGIN_Y:     org_y       = csr_wdata;
               REG_FILL_COLOR:   fill_rgb    = csr_wdata;
               REG_EDGE_COLOR:   outline_rgb = csr_wdata;
               REG_ORIENTATION:  orient_code = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_writes.size() == 0) begin
               mismatch_count++;
               $display("%0t: pixel write mismatch: expected none, got x=%0d y=%0d %s",
                        $time, rsp_screen_x, rsp_screen_y,
                        $sformatf("color=%04h last=%0b", rsp_pixel_color, rsp_last_of_run));
            end else begin
               due = expected_writes.pop_front();
               writes_checked++;
               if (due.x !== rsp_screen_x || due.y !== rsp_screen_y ||
                   due.color !== rsp_pixel_color || due.last !== rsp_last_of_run) begin
                  mismatch_count++;
                  $display("%0t: pixel write mismatch: expected x=%0d y=%0d %s, got %s",
                           $time, $signed(due.x), $signed(due.y),
                           $sformatf("color=%04h last=%0b", due.color, due.last),
                           $sformatf("x=%0d y=%0d color=%04h last=%0b", rsp_screen_x,
                                     rsp_screen_y, rsp_pixel_color, rsp_last_of_run));
               end
            end
         end
         if (req_valid && !req_stall)
            render_byte(req_bitmap_byte);
      end
      writes_due = expected_writes.size();
   end

endmodule

### tb/sv/bitmap_outline_renderer_tb.sv
// Top of the bitmap outline renderer testbench: clock, reset, stimulus and verdict.
// Depends on src/bor_pkg.sv, src/bitmap_outline_renderer.sv and the checker in this folder.
module bitmap_outline_renderer_tb
   import bor_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PHASES   = 14;
   localparam int BYTES_PER_PHASE = 25;
   // A byte with no pixel writes can still be in flight after the last expected write.
   localparam int DRAIN_CYCLES    = 24;
   localparam int LONG_HOLD       = 300;
   localparam int RUN_LIMIT_NS    = 5_000_000;
   // Index past the last register: the write must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_bitmap_byte = 8'h00;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [COORD_WIDTH-1:0] rsp_screen_x;
   logic signed [COORD_WIDTH-1:0] rsp_screen_y;
   logic [COLOR_WIDTH-1:0]        rsp_pixel_color;
   logic                          rsp_last_of_run;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata = '0;

   int mismatches;
   int writes_due;
   int writes_checked;

   // Idle rates in percent of cycles, changed between phases by the stimulus.
   int   send_gap_pct   = 0;
   int   sink_stall_pct = 0;
   // Raised by the stimulus each time the receiver should hold off for LONG_HOLD cycles.
   int   hold_requests  = 0;

   int items_sent    = 0;
   int settings_used = 0;

   bitmap_outline_renderer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_bitmap_byte (req_bitmap_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   bitmap_outline_renderer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_bitmap_byte (req_bitmap_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatches),
      .writes_due      (writes_due),
      .writes_checked  (writes_checked)
   );

   // 20 ns period: 10 ns high, 10 ns low.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver side. Every falling edge it decides whether to stall the next cycle.
   // When the stimulus asks for a hold, it keeps the stall high for a long stretch so
   // the block backs up and stalls its request side while the sender keeps offering bytes.
   initial begin : sink
      int hold_served;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            rsp_stall <= 1'b1;
            for (int k = 0; k < LONG_HOLD; k++)
               @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
         end
      end
   end

   // All stimulus tasks are entered and left at a falling edge. On leaving, nothing has
   // been assigned in that time step yet, so the caller may drive any input once.

   // Offers one byte and returns after the transaction has been accepted. The valid is
   // left high so that back-to-back bytes keep it up without a dip.
   task automatic send_byte(input logic [7:0] bits);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_bitmap_byte <= bits;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drops the request valid and waits until every predicted pixel write has come out,
   // then waits out the drain time in case a byte that writes nothing is still being walked.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (writes_due != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES)
         @(negedge clock);
   endtask

   task automatic program_all(input logic [15:0] width, input logic [15:0] height,
                              input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] fill_rgb, input logic [15:0] outline_rgb,
                              input logic [15:0] orient);
      write_reg(REG_IMAGE_WIDTH, width);
      write_reg(REG_IMAGE_HEIGHT, height);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_FILL_COLOR, fill_rgb);
      write_reg(REG_EDGE_COLOR, outline_rgb);
      write_reg(REG_ORIENTATION, orient);
      settings_used++;
   endtask

   // A 16-bit word that is an extreme value about a third of the time.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Bitmap bytes lean toward solid and run-shaped patterns, where neighbors matter.
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      int unsigned len;
      int unsigned lo;
      logic [15:0] ones;
      roll = $urandom_range(0, 99);
      if (roll < 20)
         return 8'hFF;
      if (roll < 30)
         return 8'h00;
      if (roll < 60) begin
         len  = $urandom_range(1, 8);
         lo   = $urandom_range(0, 8 - len);
         ones = (16'h1 << len) - 16'h1;
         return 8'(ones << lo);
      end
      return 8'($urandom);
   endfunction

   // Random register setting for one phase. The unused upper data bits of the narrow
   // registers carry junk so that every data bit toggles. Phase 0 and 1 pin the size
   // extremes, phase 6 has zero width and phase 9 zero height; the rest are small images
   // so rows and the image wrap often. The orientation code walks through all eight.
   task automatic program_random(input int phase);
      logic [9:0] w;
      logic [9:0] h;
      logic [5:0] junk_w;
      logic [5:0] junk_h;
      logic [12:0] junk_o;
      w      = 10'($urandom_range(1, 40));
      h      = 10'($urandom_range(1, 6));
      junk_w = 6'($urandom);
      junk_h = 6'($urandom);
      junk_o = 13'($urandom);
      case (phase)
         0: begin
            w = 10'd1023;
            h = 10'd1023;
         end
         1: begin
            w = 10'd1;
            h = 10'd1;
         end
         6: w = 10'd0;
         9: h = 10'd0;
         default: ;
      endcase
      program_all({junk_w, w}, {junk_h, h}, pick_word(), pick_word(), pick_word(),
                  pick_word(), {junk_o, 3'(phase)});
   endtask

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int phase;
      repeat (RESET_CYCLES)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First idling regime: the sender is sparse, the receiver stalls often.
      send_gap_pct   = 25;
      sink_stall_pct = 61;
      settle();

      // Two-byte rows: a full row, a pixel held across the byte boundary and resolved
      // by a set first bit, then one resolved by a clear first bit, and an empty row.
      program_all(16'd16, 16'd2, 16'd100, 16'd50, 16'h07E0, 16'hF800, 16'(ORIENT_NONE));
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h03);
      send_byte(8'h80);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      settle();

      // Padding bits past a 12-pixel row, tallest image, coordinates wrapping at 16 bits.
      program_all(16'd12, 16'd1023, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                  16'(ORIENT_HFLIP));
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hAA);
      send_byte(8'h5F);
      settle();

      // One-pixel image: every byte is a whole row and the whole image.
      program_all(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'h1234, 16'hABCD,
                  16'(ORIENT_VFLIP_ROT));
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'hFF);
      settle();

      // Widest image leaves a pixel held at column 15; the width then shrinks under
      // the walk, so the next byte places the held pixel with the new width and
      // ends the row without writing any of its own pixels.
      program_all(16'd1023, 16'd2, 16'h0010, 16'h0020, 16'h5555, 16'hAAAA,
                  16'(ORIENT_ROTLEFT));
      send_byte(8'hFF);
      send_byte(8'hFF);
      settle();
      write_reg(REG_IMAGE_WIDTH, 16'd4);
      send_byte(8'h80);
      send_byte(8'hF0);
      settle();

      // A write past the last register must be ignored.
      write_reg(REG_UNUSED, 16'hFFFF);

      // Zero width and height: every byte ends its row and nothing is written.
      program_all(16'd0, 16'd0, 16'h4321, 16'h8765, 16'hFFFF, 16'hFFFF, 16'(ORIENT_BOTH));
      send_byte(8'hFF);
      send_byte(8'h01);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Swap the idling regimes after five phases, then stop idling altogether.
         if (phase == 5) begin
            send_gap_pct   = 61;
            sink_stall_pct = 25;
         end
         if (phase == 10) begin
            send_gap_pct   = 0;
            sink_stall_pct = 0;
         end
         // Settings change only between phases, which often falls mid-row or with a
         // pixel held, so the walk carries over into the new setting.
         settle();
         program_random(phase);
         if (phase == 3 || phase == 12)
            hold_requests++;
         repeat (BYTES_PER_PHASE)
            send_byte(pick_byte());
      end

      settle();

      $display("Covered %0d bitmap bytes under %0d register settings, all orientation codes,",
               items_sent, settings_used);
      $display("size extremes and long receiver hold-offs; %0d pixel writes compared.",
               writes_checked);
      if (mismatches == 0 && writes_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
